[hdl/abl_pkg.sv]
// Package for the alternating-bit link endpoint: item types, command codes,
// register indexes and fixed constants. No dependencies.
`timescale 1ns / 1ps

package abl_pkg;

    localparam logic [1:0] CMD_RX_FRAME = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_OUT_REQ  = 2'd2;
    localparam logic [1:0] CMD_IN_TAKEN = 2'd3;

    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_RUNNING     = 2'd1;
    localparam logic [1:0] REG_DELAY_SHORT = 2'd2;
    localparam logic [1:0] REG_DELAY_LONG  = 2'd3;

    localparam logic [7:0]  MAGIC_BYTE      = 8'hAB;
    localparam logic [8:0]  HDR_BYTES       = 9'd6;
    localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd255;
    localparam logic [15:0] DELAY_SHORT_RST = 16'd512;
    localparam logic [15:0] DELAY_LONG_RST  = 16'd2048;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_magic;
        logic [7:0] rx_cur;
        logic [7:0] rx_exp;
        logic [7:0] rx_len;
        logic [8:0] rx_frame_len;
        logic [9:0] msg_len;
    } t_in_item;

    typedef struct packed {
        logic       accepted;
        logic       send_frame;
        logic [7:0] tx_cur;
        logic [7:0] tx_exp;
        logic [7:0] tx_len;
        logic [8:0] tx_frame_len;
        logic       deliver;
        logic [7:0] deliver_len;
        logic       out_released;
        logic       in_pending;
        logic       out_pending;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_wr;

endpackage

[hdl/abl_core.sv]
// Link state registers, configuration registers and per-item next-state logic.
// Depends on abl_pkg.
`timescale 1ns / 1ps

module abl_core #(
    parameter int MAX_FRAME_BYTES = 511
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  abl_pkg::t_in_item  i_item,
    input  abl_pkg::t_cfg_wr   i_cfg,
    output abl_pkg::t_out_item o_result
);

    localparam int FCAP = (MAX_FRAME_BYTES > 7) ? (MAX_FRAME_BYTES - 7) : 0;
    localparam logic [7:0] FCAP8 = (FCAP < 255) ? 8'(FCAP) : 8'd255;

    logic [7:0]  r_max_payload, n_max_payload;
    logic        r_running, n_running;
    logic [15:0] r_delay_short, n_delay_short;
    logic [15:0] r_delay_long, n_delay_long;
    logic [7:0]  r_cur_seq, n_cur_seq;
    logic [7:0]  r_exp_seq, n_exp_seq;
    logic        r_out_busy, n_out_busy;
    logic [7:0]  r_out_length, n_out_length;
    logic        r_in_busy, n_in_busy;
    logic        r_ack_due, n_ack_due;
    logic [15:0] r_next_delay, n_next_delay;
    logic [15:0] r_countdown, n_countdown;
    logic        r_timer_armed, n_timer_armed;

    logic        w_emit;
    logic        w_loop;
    logic [7:0]  w_lim;
    logic [7:0]  w_ln;
    logic [8:0]  w_body;
    abl_pkg::t_out_item w_res;

    assign w_lim = (r_max_payload > FCAP8) ? FCAP8 : r_max_payload;

    always_comb begin
        n_max_payload = r_max_payload;
        n_running     = r_running;
        n_delay_short = r_delay_short;
        n_delay_long  = r_delay_long;
        n_cur_seq     = r_cur_seq;
        n_exp_seq     = r_exp_seq;
        n_out_busy    = r_out_busy;
        n_out_length  = r_out_length;
        n_in_busy     = r_in_busy;
        n_ack_due     = r_ack_due;
        n_next_delay  = r_next_delay;
        n_countdown   = r_countdown;
        n_timer_armed = r_timer_armed;
        w_emit        = 1'b0;
        w_loop        = 1'b0;
        w_res         = '0;
        w_body        = i_item.rx_frame_len - abl_pkg::HDR_BYTES;

        if (i_step) begin
            case (i_item.command)
                abl_pkg::CMD_RX_FRAME: begin
                    w_loop = 1'b1;
                    if (i_item.rx_magic == abl_pkg::MAGIC_BYTE) begin
                        if (r_out_busy) begin
                            if (i_item.rx_exp != r_cur_seq) begin
                                n_out_busy = 1'b0;
                                w_res.out_released = 1'b1;
                                n_cur_seq = i_item.rx_exp;
                            end else begin
                                n_next_delay = r_delay_short;
                            end
                        end else begin
                            n_cur_seq = i_item.rx_exp;
                        end
                        if (i_item.rx_frame_len > abl_pkg::HDR_BYTES) begin
                            if (i_item.rx_cur != r_exp_seq) begin
                                n_next_delay = r_delay_short;
                            end else if (i_item.rx_len != 8'd0 &&
                                         {1'b0, i_item.rx_len} <= w_body) begin
                                n_in_busy = 1'b1;
                                w_res.deliver = 1'b1;
                                w_res.deliver_len = i_item.rx_len;
                                n_exp_seq = r_exp_seq + 8'd1;
                                n_ack_due = 1'b1;
                            end
                        end
                    end
                end
                abl_pkg::CMD_TICK: begin
                    if (r_running && r_timer_armed) begin
                        if (r_countdown <= 16'd1) begin
                            w_emit = 1'b1;
                            n_countdown = n_next_delay;
                            n_next_delay = r_delay_long;
                        end else begin
                            n_countdown = r_countdown - 16'd1;
                        end
                    end
                end
                abl_pkg::CMD_OUT_REQ: begin
                    if (!r_out_busy && r_running) begin
                        w_res.accepted = 1'b1;
                        n_out_busy = 1'b1;
                        n_out_length = (i_item.msg_len > 10'd255) ? 8'd255
                                                                  : i_item.msg_len[7:0];
                        n_ack_due = 1'b1;
                        w_loop = 1'b1;
                    end
                end
                abl_pkg::CMD_IN_TAKEN: begin
                    if (r_in_busy) begin
                        n_in_busy = 1'b0;
                        w_loop = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (w_loop) begin
                if (r_running) begin
                    if (n_ack_due) begin
                        w_emit = 1'b1;
                    end
                    if (!r_timer_armed || n_next_delay < r_countdown) begin
                        n_countdown = n_next_delay;
                    end
                    n_timer_armed = 1'b1;
                    n_next_delay = r_delay_long;
                end else begin
                    n_timer_armed = 1'b0;
                end
            end

            if (w_emit) begin
                n_ack_due = 1'b0;
            end
        end

        // frame header built from the state as it stands after the event
        w_ln = n_out_busy ? n_out_length : 8'd0;
        if (w_ln > w_lim) begin
            w_ln = w_lim;
        end
        if (w_emit) begin
            w_res.send_frame   = 1'b1;
            w_res.tx_cur       = n_cur_seq;
            w_res.tx_exp       = n_exp_seq;
            w_res.tx_len       = w_ln;
            w_res.tx_frame_len = {1'b0, w_ln} + abl_pkg::HDR_BYTES + {8'd0, w_ln[0]};
        end
        w_res.in_pending  = n_in_busy;
        w_res.out_pending = n_out_busy;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                abl_pkg::REG_MAX_PAYLOAD: n_max_payload = i_cfg.data[7:0];
                abl_pkg::REG_RUNNING: begin
                    n_running = i_cfg.data[0];
                    if (!i_cfg.data[0]) begin
                        n_timer_armed = 1'b0;
                    end else if (!r_timer_armed) begin
                        n_countdown   = r_next_delay;
                        n_timer_armed = 1'b1;
                        n_next_delay  = r_delay_long;
                    end
                end
                abl_pkg::REG_DELAY_SHORT: n_delay_short = i_cfg.data;
                abl_pkg::REG_DELAY_LONG:  n_delay_long  = i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= abl_pkg::MAX_PAYLOAD_RST;
            r_running     <= 1'b1;
            r_delay_short <= abl_pkg::DELAY_SHORT_RST;
            r_delay_long  <= abl_pkg::DELAY_LONG_RST;
            r_cur_seq     <= '0;
            r_exp_seq     <= '0;
            r_out_busy    <= 1'b0;
            r_out_length  <= '0;
            r_in_busy     <= 1'b0;
            r_ack_due     <= 1'b0;
            r_next_delay  <= abl_pkg::DELAY_SHORT_RST;
            r_countdown   <= '0;
            r_timer_armed <= 1'b0;
        end else begin
            r_max_payload <= n_max_payload;
            r_running     <= n_running;
            r_delay_short <= n_delay_short;
            r_delay_long  <= n_delay_long;
            r_cur_seq     <= n_cur_seq;
            r_exp_seq     <= n_exp_seq;
            r_out_busy    <= n_out_busy;
            r_out_length  <= n_out_length;
            r_in_busy     <= n_in_busy;
            r_ack_due     <= n_ack_due;
            r_next_delay  <= n_next_delay;
            r_countdown   <= n_countdown;
            r_timer_armed <= n_timer_armed;
        end
    end

    a_off_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> !r_timer_armed)
        else $error("timer armed while not running");

    a_frame_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_res.send_frame |-> !w_res.tx_frame_len[0] &&
                                       w_res.tx_frame_len >= abl_pkg::HDR_BYTES)
        else $error("bad frame length");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_res.accepted |=> r_out_busy && !r_ack_due)
        else $error("accepted request not held");

    a_deliver_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_res.deliver |=> r_in_busy && r_exp_seq == $past(r_exp_seq) + 8'd1)
        else $error("delivery did not update inbound state");

endmodule

[hdl/abl_out_reg.sv]
// Result register toward the output channel, with valid and stall.
// Depends on abl_pkg.
`timescale 1ns / 1ps

module abl_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  abl_pkg::t_out_item i_item,
    output logic               o_ready,
    output logic               o_valid,
    output abl_pkg::t_out_item o_item,
    input  logic               i_stall
);

    logic               r_valid;
    abl_pkg::t_out_item r_item;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[hdl/alternating_bit_link_endpoint_unit.sv]
// Alternating-bit link endpoint: input register, link state core, result register.
// An accepted item passes the input register, the core, then the result register.
// Throughput: 1 item per cycle when not stalled; a state update is one core pass.
// Reset (synchronous, active low) clears the link state and loads register defaults.
// Depends on abl_pkg, abl_core and abl_out_reg.
`timescale 1ns / 1ps

module alternating_bit_link_endpoint_unit #(
    parameter int MAX_FRAME_BYTES = 511
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  abl_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output abl_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    logic               r_s1_valid;
    abl_pkg::t_in_item  r_s1_item;
    logic               w_out_ready;
    logic               w_step;
    abl_pkg::t_cfg_wr   w_cfg;
    abl_pkg::t_out_item w_result;

    assign o_cfg_ready = 1'b1;
    assign w_cfg       = {i_cfg_valid, i_cfg_index, i_cfg_data};

    assign w_step     = r_s1_valid && w_out_ready;
    assign o_in_stall = r_s1_valid && !w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_item <= i_in_item;
        end
    end

    abl_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_s1_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    abl_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_item  (w_result),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule

[test/alternating_bit_link_endpoint_unit_test.sv]
// Self-checking testbench for alternating_bit_link_endpoint_unit: directed link events,
// register settings and randomized partner traffic, each result checked against a predictor.
// Depends on abl_pkg and the endpoint RTL.
`timescale 1ns / 1ps

module alternating_bit_link_endpoint_unit_test;

    localparam int MAX_FRAME_BYTES = 511;
    localparam int FRAME_CAP       = MAX_FRAME_BYTES - 7;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 10;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    abl_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    abl_pkg::t_out_item o_out_item;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    alternating_bit_link_endpoint_unit #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // predicted endpoint state and register copies
    logic [7:0]  cfg_max_payload;
    logic        cfg_running;
    logic [15:0] cfg_delay_short;
    logic [15:0] cfg_delay_long;
    logic [7:0]  seq_cur;
    logic [7:0]  seq_exp;
    logic        tx_busy;
    logic [7:0]  tx_len_held;
    logic        rx_held;
    logic        ack_owed;
    logic [15:0] delay_next;
    logic [15:0] tick_count;
    logic        tick_armed;

    abl_pkg::t_out_item responses_due[$];

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned responses_checked;
    int unsigned frames_seen;
    int unsigned deliveries_seen;
    int unsigned releases_seen;
    int unsigned settings_count;
    logic        quiet_in;
    logic        quiet_out;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void reset_endpoint_model();
        cfg_max_payload = abl_pkg::MAX_PAYLOAD_RST;
        cfg_running     = 1'b1;
        cfg_delay_short = abl_pkg::DELAY_SHORT_RST;
        cfg_delay_long  = abl_pkg::DELAY_LONG_RST;
        seq_cur         = '0;
        seq_exp         = '0;
        tx_busy         = 1'b0;
        tx_len_held     = '0;
        rx_held         = 1'b0;
        ack_owed        = 1'b0;
        delay_next      = abl_pkg::DELAY_SHORT_RST;
        tick_count      = '0;
        tick_armed      = 1'b0;
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [15:0] val);
        case (idx)
            abl_pkg::REG_MAX_PAYLOAD: cfg_max_payload = val[7:0];
            abl_pkg::REG_RUNNING: begin
                cfg_running = val[0];
                if (!cfg_running) begin
                    tick_armed = 1'b0;
                end else if (!tick_armed) begin
                    tick_count = delay_next;
                    tick_armed = 1'b1;
                    delay_next = cfg_delay_long;
                end
            end
            abl_pkg::REG_DELAY_SHORT: cfg_delay_short = val;
            default: cfg_delay_long = val;
        endcase
    endfunction

    function automatic void put_header(inout abl_pkg::t_out_item r);
        int lim;
        int ln;
        lim = int'(cfg_max_payload);
        if (lim > FRAME_CAP) lim = FRAME_CAP;
        ln = tx_busy ? int'(tx_len_held) : 0;
        if (ln > lim) ln = lim;
        r.send_frame   = 1'b1;
        r.tx_cur       = seq_cur;
        r.tx_exp       = seq_exp;
        r.tx_len       = 8'(ln);
        r.tx_frame_len = 9'(ln + int'(abl_pkg::HDR_BYTES) + (ln & 1));
        ack_owed       = 1'b0;
    endfunction

    function automatic void service_pass(inout abl_pkg::t_out_item r);
        if (!cfg_running) begin
            tick_armed = 1'b0;
        end else begin
            if (ack_owed) put_header(r);
            if (!tick_armed || delay_next < tick_count) tick_count = delay_next;
            tick_armed = 1'b1;
            delay_next = cfg_delay_long;
        end
    endfunction

    function automatic void absorb_frame(abl_pkg::t_in_item it, inout abl_pkg::t_out_item r);
        int flen;
        flen = int'(it.rx_frame_len);
        if (it.rx_magic != abl_pkg::MAGIC_BYTE) return;
        if (tx_busy) begin
            if (it.rx_exp != seq_cur) begin
                tx_busy        = 1'b0;
                r.out_released = 1'b1;
                seq_cur        = it.rx_exp;
            end else begin
                delay_next = cfg_delay_short;
            end
        end else begin
            seq_cur = it.rx_exp;
        end
        if (flen <= int'(abl_pkg::HDR_BYTES)) return;
        if (it.rx_cur != seq_exp) begin
            delay_next = cfg_delay_short;
            return;
        end
        if (it.rx_len == 8'd0 || int'(it.rx_len) > flen - int'(abl_pkg::HDR_BYTES)) return;
        rx_held       = 1'b1;
        r.deliver     = 1'b1;
        r.deliver_len = it.rx_len;
        seq_exp       = seq_exp + 8'd1;
        ack_owed      = 1'b1;
    endfunction

    function automatic abl_pkg::t_out_item endpoint_response(abl_pkg::t_in_item it);
        abl_pkg::t_out_item r;
        r = '0;
        case (it.command)
            abl_pkg::CMD_RX_FRAME: begin
                absorb_frame(it, r);
                service_pass(r);
            end
            abl_pkg::CMD_TICK: begin
                if (cfg_running && tick_armed) begin
                    if (tick_count <= 16'd1) begin
                        put_header(r);
                        tick_count = delay_next;
                        delay_next = cfg_delay_long;
                    end else begin
                        tick_count = tick_count - 16'd1;
                    end
                end
            end
            abl_pkg::CMD_OUT_REQ: begin
                if (!tx_busy && cfg_running) begin
                    r.accepted  = 1'b1;
                    tx_busy     = 1'b1;
                    tx_len_held = (it.msg_len > 10'd255) ? 8'd255 : it.msg_len[7:0];
                    ack_owed    = 1'b1;
                    service_pass(r);
                end
            end
            default: begin
                if (rx_held) begin
                    rx_held = 1'b0;
                    service_pass(r);
                end
            end
        endcase
        r.in_pending  = rx_held;
        r.out_pending = tx_busy;
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        abl_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (responses_due.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatches++;
            end else begin
                want = responses_due.pop_front();
                responses_checked++;
                if (want.send_frame) frames_seen++;
                if (want.deliver) deliveries_seen++;
                if (want.out_released) releases_seen++;
                check_field("accepted", 16'(want.accepted), 16'(o_out_item.accepted));
                check_field("send_frame", 16'(want.send_frame), 16'(o_out_item.send_frame));
                check_field("tx_cur", 16'(want.tx_cur), 16'(o_out_item.tx_cur));
                check_field("tx_exp", 16'(want.tx_exp), 16'(o_out_item.tx_exp));
                check_field("tx_len", 16'(want.tx_len), 16'(o_out_item.tx_len));
                check_field("tx_frame_len", 16'(want.tx_frame_len),
                            16'(o_out_item.tx_frame_len));
                check_field("deliver", 16'(want.deliver), 16'(o_out_item.deliver));
                check_field("deliver_len", 16'(want.deliver_len),
                            16'(o_out_item.deliver_len));
                check_field("out_released", 16'(want.out_released),
                            16'(o_out_item.out_released));
                check_field("in_pending", 16'(want.in_pending), 16'(o_out_item.in_pending));
                check_field("out_pending", 16'(want.out_pending),
                            16'(o_out_item.out_pending));
            end
        end
    end

    // output back-pressure: short runs of stall, now and then a long one
    initial begin : out_stall_gen
        int unsigned run;
        int unsigned hold;
        int unsigned pick;
        i_out_stall = 1'b0;
        forever begin
            run = quiet_out ? 40 : $urandom_range(0, 12);
            repeat (run) @(negedge i_clk);
            if (!quiet_out) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) hold = $urandom_range(1, 2);
                else if (pick < 95) hold = $urandom_range(3, 8);
                else hold = $urandom_range(20, 50);
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic int unsigned input_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (quiet_in || pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    task automatic send_item(abl_pkg::t_in_item it);
        int unsigned gap;
        gap = input_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        responses_due.push_back(endpoint_response(it));
        items_sent++;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (responses_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        idle_input();
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_register(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic abl_pkg::t_in_item random_item();
        abl_pkg::t_in_item it;
        it.command      = 2'($urandom);
        it.rx_magic     = 8'($urandom);
        it.rx_cur       = 8'($urandom);
        it.rx_exp       = 8'($urandom);
        it.rx_len       = 8'($urandom);
        it.rx_frame_len = 9'($urandom);
        it.msg_len      = 10'($urandom);
        return it;
    endfunction

    function automatic abl_pkg::t_in_item cmd_item(logic [1:0] cmd);
        abl_pkg::t_in_item it;
        it = random_item();
        it.command = cmd;
        return it;
    endfunction

    function automatic abl_pkg::t_in_item rx_frame(logic [7:0] magic, logic [7:0] scur,
                                                   logic [7:0] sexp, logic [7:0] len,
                                                   logic [8:0] flen);
        abl_pkg::t_in_item it;
        it = cmd_item(abl_pkg::CMD_RX_FRAME);
        it.rx_magic     = magic;
        it.rx_cur       = scur;
        it.rx_exp       = sexp;
        it.rx_len       = len;
        it.rx_frame_len = flen;
        return it;
    endfunction

    // partner-like traffic built on the predicted sequence state
    function automatic abl_pkg::t_in_item link_item();
        abl_pkg::t_in_item it;
        int unsigned pick;
        it = random_item();
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            it.command = abl_pkg::CMD_RX_FRAME;
            if ($urandom_range(0, 19) != 0) it.rx_magic = abl_pkg::MAGIC_BYTE;
            pick = $urandom_range(0, 9);
            if (pick < 7) it.rx_cur = seq_exp;
            else if (pick < 9) it.rx_cur = seq_exp - 8'd1;
            pick = $urandom_range(0, 9);
            if (pick < 5) it.rx_exp = seq_cur + 8'd1;
            else if (pick < 8) it.rx_exp = seq_cur;
            if ($urandom_range(0, 9) < 6) it.rx_len = 8'($urandom_range(0, 40));
            pick = $urandom_range(0, 9);
            if (pick < 7)
                it.rx_frame_len = 9'(int'(it.rx_len) + int'(abl_pkg::HDR_BYTES) +
                                     $urandom_range(0, 3));
            else if (pick < 8)
                it.rx_frame_len = 9'($urandom_range(0, 6));
        end else if (pick < 70) begin
            it.command = abl_pkg::CMD_TICK;
        end else if (pick < 85) begin
            it.command = abl_pkg::CMD_OUT_REQ;
            if ($urandom_range(0, 1) == 0) it.msg_len = 10'($urandom_range(0, 300));
        end else begin
            it.command = abl_pkg::CMD_IN_TAKEN;
        end
        return it;
    endfunction

    task automatic test_directed_events();
        abl_pkg::t_in_item it;
        send_item(cmd_item(abl_pkg::CMD_IN_TAKEN));
        send_item(cmd_item(abl_pkg::CMD_TICK));
        it = cmd_item(abl_pkg::CMD_OUT_REQ);
        it.msg_len = 10'd1023;
        send_item(it);
        send_item(it);
        send_item(rx_frame(8'h00, 8'hFF, 8'hFF, 8'hFF, 9'd511));
        send_item(rx_frame(8'hFF, 8'h00, 8'h00, 8'h00, 9'd0));
        send_item(rx_frame(abl_pkg::MAGIC_BYTE, seq_exp, seq_cur, 8'd10, 9'd0));
        send_item(rx_frame(abl_pkg::MAGIC_BYTE, seq_exp, seq_cur + 8'd1, 8'd255, 9'd511));
        send_item(rx_frame(abl_pkg::MAGIC_BYTE, seq_exp - 8'd1, seq_cur, 8'd5, 9'd100));
        send_item(rx_frame(abl_pkg::MAGIC_BYTE, seq_exp, seq_cur, 8'd0, 9'd50));
        send_item(rx_frame(abl_pkg::MAGIC_BYTE, seq_exp, seq_cur, 8'd200, 9'd205));
        send_item(rx_frame(abl_pkg::MAGIC_BYTE, seq_exp, seq_cur, 8'd199, 9'd205));
        send_item(cmd_item(abl_pkg::CMD_IN_TAKEN));
        send_item(cmd_item(abl_pkg::CMD_IN_TAKEN));
        it = cmd_item(abl_pkg::CMD_OUT_REQ);
        it.msg_len = 10'd0;
        send_item(it);
        send_item(cmd_item(abl_pkg::CMD_TICK));
    endtask

    task automatic test_register_settings();
        abl_pkg::t_in_item it;
        write_reg(abl_pkg::REG_DELAY_SHORT, 16'd0);
        write_reg(abl_pkg::REG_DELAY_LONG, 16'd1);
        write_reg(abl_pkg::REG_MAX_PAYLOAD, 16'd7);
        settings_count++;
        send_item(rx_frame(abl_pkg::MAGIC_BYTE, seq_exp - 8'd1, seq_cur + 8'd1, 8'd0, 9'd0));
        it = cmd_item(abl_pkg::CMD_OUT_REQ);
        it.msg_len = 10'd1023;
        send_item(it);
        repeat (3) send_item(cmd_item(abl_pkg::CMD_TICK));
        // receive only: frames still land, nothing goes out
        write_reg(abl_pkg::REG_RUNNING, 16'd0);
        settings_count++;
        send_item(cmd_item(abl_pkg::CMD_TICK));
        send_item(rx_frame(abl_pkg::MAGIC_BYTE, seq_exp, seq_cur + 8'd1, 8'd3, 9'd9));
        send_item(it);
        write_reg(abl_pkg::REG_RUNNING, 16'd1);
        write_reg(abl_pkg::REG_MAX_PAYLOAD, 16'd0);
        settings_count++;
        send_item(cmd_item(abl_pkg::CMD_TICK));
        send_item(it);
        write_reg(abl_pkg::REG_DELAY_SHORT, 16'hFFFF);
        write_reg(abl_pkg::REG_DELAY_LONG, 16'hFFFF);
        write_reg(abl_pkg::REG_MAX_PAYLOAD, 16'd255);
        settings_count++;
        send_item(rx_frame(abl_pkg::MAGIC_BYTE, seq_exp, seq_cur, 8'd1, 9'd7));
        send_item(cmd_item(abl_pkg::CMD_TICK));
    endtask

    task automatic run_phase(logic [7:0] max_pl, logic run, logic [15:0] dshort,
                             logic [15:0] dlong, int unsigned count);
        write_reg(abl_pkg::REG_MAX_PAYLOAD, {8'd0, max_pl});
        write_reg(abl_pkg::REG_DELAY_SHORT, dshort);
        write_reg(abl_pkg::REG_DELAY_LONG, dlong);
        write_reg(abl_pkg::REG_RUNNING, {15'd0, run});
        settings_count++;
        repeat (count) send_item(link_item());
    endtask

    task automatic test_link_traffic();
        run_phase(8'd255, 1'b1, 16'd2, 16'd5, 130);
        quiet_in  = 1'b1;
        quiet_out = 1'b1;
        run_phase(8'd0, 1'b1, 16'd1, 16'd1, 80);
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
        run_phase(8'($urandom), 1'b1, 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 20)), 60);
        idle_input();
        wait_drained();
        repeat (60) send_item(link_item());
        run_phase(8'($urandom), 1'b0, 16'd3, 16'd4, 60);
        run_phase(8'd255, 1'b1, 16'hFFFF, 16'd3, 80);
        run_phase(8'($urandom_range(1, 254)), 1'b1, 16'd3, 16'd40, 100);
    endtask

    task automatic test_random_noise();
        run_phase(8'($urandom), 1'b1, 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 8)), 0);
        repeat (80) send_item(random_item());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        quiet_in    = 1'b0;
        quiet_out   = 1'b0;
        reset_endpoint_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settings_count = 1;

        test_directed_events();
        test_register_settings();
        test_link_traffic();
        test_random_noise();

        idle_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d items under %0d register settings; %0d results checked,",
                 items_sent, settings_count, responses_checked);
        $display("including %0d frames sent, %0d deliveries and %0d releases.",
                 frames_seen, deliveries_seen, releases_seen);
        if (mismatches == 0 && responses_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
